// ===== hdl/triangle_bbox_rasterizer_core_defines.svh =====
// Assertion macros for the checker module of the rasterizer core.
// Included by the checker module; needs nothing else.
`ifndef TRIANGLE_BBOX_RASTERIZER_CORE_DEFINES_SVH
`define TRIANGLE_BBOX_RASTERIZER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge
`define TBR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge
`define TBR_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/tbr_pkg.sv =====
// Package for the triangle bounding-box rasterizer core: constants, register map,
// controller state type and the command/status structs between controller and datapath.
// No dependencies.
package tbr_pkg;

   // default geometry
   localparam int COORD_BITS_DEF = 8;
   localparam int COUNT_BITS_DEF = 16;

   // fixed field widths
   localparam int DEPTH_BITS = 8;
   localparam int COLOR_BITS = 8;

   // register map
   localparam int                      CSR_DATA_BITS = 32;
   localparam int                      CSR_ADDR_BITS = 3;
   localparam logic [0:0]              CSR_IDX_COLOR = 1'b0;
   localparam logic [COLOR_BITS-1:0]   COLOR_RESET   = 8'd100;

   // item kinds carried on tuser
   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_TICK = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_EMIT
   } ctrl_state_type;

   typedef struct packed {
      logic load;   // store a new triangle from the input item
      logic calc;   // register the edge products
      logic emit;   // write the result register
      logic tick;   // item in flight is a scan tick
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;  // result register can take a new item
   } dp_status_type;

endpackage

// ===== hdl/tbr_csr.sv =====
// Configuration register block of the rasterizer core (fragment color).
// Depends on tbr_pkg.
module tbr_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [tbr_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [tbr_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [tbr_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                csr_pready,
   output logic [tbr_pkg::COLOR_BITS-1:0]      color
);

   logic [tbr_pkg::COLOR_BITS-1:0] color_ff;
   logic [tbr_pkg::COLOR_BITS-1:0] color_in;
   logic [0:0]                     reg_idx;
   logic                           wr_color;

   // word index from the byte address
   assign reg_idx  = csr_paddr[tbr_pkg::CSR_ADDR_BITS-1:2];
   assign wr_color = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                     (reg_idx == tbr_pkg::CSR_IDX_COLOR);

   assign color_in = wr_color ? csr_pwdata[tbr_pkg::COLOR_BITS-1:0] : color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff <= tbr_pkg::COLOR_RESET;
      end else begin
         color_ff <= color_in;
      end
   end

   // read back
   always_comb begin
      csr_prdata = '0;
      if (reg_idx == tbr_pkg::CSR_IDX_COLOR) begin
         csr_prdata = tbr_pkg::CSR_DATA_BITS'(color_ff);
      end
   end

   assign csr_pready = 1'b1;
   assign color      = color_ff;

endmodule

// ===== hdl/tbr_ctrl.sv =====
// Controller of the rasterizer core: accept / product / emit sequencer.
// Depends on tbr_pkg.
module tbr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_mode,
   input  tbr_pkg::dp_status_type status,
   output logic                   req_ready,
   output tbr_pkg::dp_cmd_type    cmd
);

   tbr_pkg::ctrl_state_type state_ff;
   tbr_pkg::ctrl_state_type state_in;
   logic                    tick_ff;
   logic                    tick_in;
   logic                    accept;

   assign accept = req_valid && (state_ff == tbr_pkg::ST_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tbr_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = tbr_pkg::ST_CALC;
            end
         end
         tbr_pkg::ST_CALC: begin
            state_in = tbr_pkg::ST_EMIT;
         end
         tbr_pkg::ST_EMIT: begin
            if (status.out_free) begin
               state_in = tbr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tbr_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      cmd.tick  = tick_ff;
      unique case (state_ff)
         tbr_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid && (req_mode == tbr_pkg::MODE_LOAD);
         end
         tbr_pkg::ST_CALC: begin
            cmd.calc = 1'b1;
         end
         tbr_pkg::ST_EMIT: begin
            cmd.emit = status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // item kind held while it is in flight
   assign tick_in = accept ? (req_mode == tbr_pkg::MODE_TICK) : tick_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tbr_pkg::ST_IDLE;
         tick_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         tick_ff  <= tick_in;
      end
   end

endmodule

// ===== hdl/tbr_dp.sv =====
// Datapath of the rasterizer core: triangle store, scan counters, edge products,
// coverage test and the result register.
// Depends on tbr_pkg.
module tbr_dp #(
   parameter int COORD_BITS = tbr_pkg::COORD_BITS_DEF,
   parameter int COUNT_BITS = tbr_pkg::COUNT_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  tbr_pkg::dp_cmd_type               cmd,
   output tbr_pkg::dp_status_type            status,
   input  logic [COORD_BITS-1:0]             vert0_x,
   input  logic [COORD_BITS-1:0]             vert0_y,
   input  logic [COORD_BITS-1:0]             vert1_x,
   input  logic [COORD_BITS-1:0]             vert1_y,
   input  logic [COORD_BITS-1:0]             vert2_x,
   input  logic [COORD_BITS-1:0]             vert2_y,
   input  logic [tbr_pkg::DEPTH_BITS-1:0]    depth_in,
   input  logic [COORD_BITS-1:0]             box_min_x,
   input  logic [COORD_BITS-1:0]             box_min_y,
   input  logic [COORD_BITS:0]               box_width,
   input  logic [COUNT_BITS-1:0]             box_count,
   input  logic [tbr_pkg::COLOR_BITS-1:0]    color,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic                              covered,
   output logic [COORD_BITS-1:0]             frag_x,
   output logic [COORD_BITS-1:0]             frag_y,
   output logic [tbr_pkg::DEPTH_BITS-1:0]    frag_z,
   output logic [tbr_pkg::COLOR_BITS-1:0]    frag_color,
   output logic                              scan_done
);

   localparam int DIFF_BITS = COORD_BITS + 1;
   localparam int PROD_BITS = 2 * DIFF_BITS;
   localparam int EDGE_BITS = PROD_BITS + 1;

   // triangle and scan state
   logic [COORD_BITS-1:0]          vert_ff [6];
   logic [tbr_pkg::DEPTH_BITS-1:0] depth_ff;
   logic [COORD_BITS-1:0]          origin_x_ff;
   logic [COORD_BITS:0]            width_ff;
   logic [COORD_BITS:0]            width_in;
   logic [COUNT_BITS-1:0]          total_ff;
   logic [COUNT_BITS-1:0]          total_in;
   logic [COUNT_BITS-1:0]          index_ff;
   logic [COUNT_BITS-1:0]          index_in;
   logic [COORD_BITS:0]            col_ff;
   logic [COORD_BITS-1:0]          cur_x_ff;
   logic [COORD_BITS-1:0]          cur_y_ff;

   // edge products: two per edge
   logic signed [PROD_BITS-1:0]    prod_a_ff [3];
   logic signed [PROD_BITS-1:0]    prod_b_ff [3];
   logic signed [PROD_BITS-1:0]    prod_a_in [3];
   logic signed [PROD_BITS-1:0]    prod_b_in [3];
   logic [2:0]                     edge_neg;

   // result register
   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   logic                           covered_ff;
   logic                           covered_in;
   logic [COORD_BITS-1:0]          frag_x_ff;
   logic [COORD_BITS-1:0]          frag_x_in;
   logic [COORD_BITS-1:0]          frag_y_ff;
   logic [COORD_BITS-1:0]          frag_y_in;
   logic [tbr_pkg::DEPTH_BITS-1:0] frag_z_ff;
   logic [tbr_pkg::DEPTH_BITS-1:0] frag_z_in;
   logic [tbr_pkg::COLOR_BITS-1:0] frag_color_ff;
   logic [tbr_pkg::COLOR_BITS-1:0] frag_color_in;
   logic                           done_ff;
   logic                           done_in;

   logic                           scan_over;
   logic                           step;
   logic [COUNT_BITS:0]            index_next;
   logic                           last_col;

   assign scan_over  = (width_ff == '0) || (index_ff >= total_ff);
   assign step       = cmd.emit && cmd.tick && !scan_over;
   assign index_next = {1'b0, index_ff} + {{COUNT_BITS{1'b0}}, 1'b1};
   assign last_col   = (col_ff == (width_ff - {{COORD_BITS{1'b0}}, 1'b1}));

   // triangle store, written on load
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         vert_ff[0]  <= vert0_x;
         vert_ff[1]  <= vert0_y;
         vert_ff[2]  <= vert1_x;
         vert_ff[3]  <= vert1_y;
         vert_ff[4]  <= vert2_x;
         vert_ff[5]  <= vert2_y;
         depth_ff    <= depth_in;
         origin_x_ff <= box_min_x;
      end
   end

   // scan limits and index
   always_comb begin
      width_in = width_ff;
      total_in = total_ff;
      index_in = index_ff;
      if (cmd.load) begin
         width_in = box_width;
         total_in = box_count;
         index_in = '0;
      end else if (step) begin
         index_in = index_next[COUNT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= '0;
         total_ff <= '0;
         index_ff <= '0;
      end else begin
         width_ff <= width_in;
         total_ff <= total_in;
         index_ff <= index_in;
      end
   end

   // column and row walk replacing k mod width and k div width
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         col_ff   <= '0;
         cur_x_ff <= box_min_x;
         cur_y_ff <= box_min_y;
      end else if (step) begin
         if (last_col) begin
            col_ff   <= '0;
            cur_x_ff <= origin_x_ff;
            cur_y_ff <= cur_y_ff + {{(COORD_BITS-1){1'b0}}, 1'b1};
         end else begin
            col_ff   <= col_ff + {{COORD_BITS{1'b0}}, 1'b1};
            cur_x_ff <= cur_x_ff + {{(COORD_BITS-1){1'b0}}, 1'b1};
         end
      end
   end

   // edge i runs from vertex i to vertex i+1:
   // E = (px - ax)*(by - ay) - (py - ay)*(bx - ax)
   for (genvar g = 0; g < 3; g++) begin : g_edge
      localparam int NX = (g == 2) ? 0 : g + 1;
      logic signed [DIFF_BITS-1:0] dpx;
      logic signed [DIFF_BITS-1:0] dpy;
      logic signed [DIFF_BITS-1:0] dex;
      logic signed [DIFF_BITS-1:0] dey;
      logic signed [EDGE_BITS-1:0] edge_val;

      assign dpx = $signed({1'b0, cur_x_ff}) - $signed({1'b0, vert_ff[2*g]});
      assign dpy = $signed({1'b0, cur_y_ff}) - $signed({1'b0, vert_ff[2*g+1]});
      assign dex = $signed({1'b0, vert_ff[2*NX]}) - $signed({1'b0, vert_ff[2*g]});
      assign dey = $signed({1'b0, vert_ff[2*NX+1]}) - $signed({1'b0, vert_ff[2*g+1]});

      assign prod_a_in[g] = dpx * dey;
      assign prod_b_in[g] = dpy * dex;

      always_ff @(posedge clock) begin
         if (cmd.calc) begin
            prod_a_ff[g] <= prod_a_in[g];
            prod_b_ff[g] <= prod_b_in[g];
         end
      end

      assign edge_val = $signed({prod_a_ff[g][PROD_BITS-1], prod_a_ff[g]}) -
                        $signed({prod_b_ff[g][PROD_BITS-1], prod_b_ff[g]});
      assign edge_neg[g] = edge_val[EDGE_BITS-1];
   end

   // result contents
   always_comb begin
      covered_in    = 1'b0;
      frag_x_in     = '0;
      frag_y_in     = '0;
      frag_z_in     = '0;
      frag_color_in = '0;
      done_in       = scan_over;
      if (cmd.tick && !scan_over) begin
         covered_in    = (edge_neg == 3'b000);
         frag_x_in     = cur_x_ff;
         frag_y_in     = cur_y_ff;
         frag_z_in     = depth_ff;
         frag_color_in = color;
         done_in       = (index_next >= {1'b0, total_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         covered_ff    <= covered_in;
         frag_x_ff     <= frag_x_in;
         frag_y_ff     <= frag_y_in;
         frag_z_ff     <= frag_z_in;
         frag_color_ff <= frag_color_in;
         done_ff       <= done_in;
      end
   end

   // result valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid  = rsp_valid_ff;
   assign covered    = covered_ff;
   assign frag_x     = frag_x_ff;
   assign frag_y     = frag_y_ff;
   assign frag_z     = frag_z_ff;
   assign frag_color = frag_color_ff;
   assign scan_done  = done_ff;

endmodule

// ===== hdl/triangle_bbox_rasterizer_core.sv =====
// Top level of the triangle bounding-box rasterizer (Pineda edge functions).
// Depends on tbr_pkg, tbr_csr, tbr_ctrl and tbr_dp.
//
//   port group   direction   carries
//   req_*        in          one item: load a triangle or scan one pixel
//   rsp_*        out         one result item per input item
//   csr_*        in/out      register access (fragment_color at byte 0)
//
// Each item goes through the accept step, the edge products, then the edge
// sums, coverage test and result write. The six products are the slow part.
// A new item is taken once the previous one has reached the result register,
// even if that result is not yet taken; a stalled result holds the sequencer
// in its last step. Reset is synchronous and needs no clearing pass.
module triangle_bbox_rasterizer_core #(
   parameter int COORD_BITS = tbr_pkg::COORD_BITS_DEF,
   parameter int COUNT_BITS = tbr_pkg::COUNT_BITS_DEF,
   localparam int REQ_BITS       = 9 * COORD_BITS + 9 + COUNT_BITS,
   localparam int REQ_TDATA_BITS = ((REQ_BITS + 7) / 8) * 8,
   localparam int RSP_BITS       = 2 * COORD_BITS + tbr_pkg::DEPTH_BITS + tbr_pkg::COLOR_BITS,
   localparam int RSP_TDATA_BITS = ((RSP_BITS + 7) / 8) * 8
) (
   input  logic                              clock,
   input  logic                              reset,
   // vert0_x, vert0_y, vert1_x, vert1_y, vert2_x, vert2_y, depth_in,
   // box_min_x, box_min_y, box_width, box_count (lowest first)
   input  logic [REQ_TDATA_BITS-1:0]         req_tdata,
   // mode
   input  logic                              req_tuser,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // frag_x, frag_y, frag_z, frag_color (lowest first)
   output logic [RSP_TDATA_BITS-1:0]         rsp_tdata,
   // covered
   output logic                              rsp_tuser,
   // scan_done
   output logic                              rsp_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [tbr_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [tbr_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [tbr_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                              csr_pready
);

   localparam int C = COORD_BITS;
   localparam int OFS_DEPTH = 6 * C;
   localparam int OFS_MINX  = OFS_DEPTH + tbr_pkg::DEPTH_BITS;
   localparam int OFS_MINY  = OFS_MINX + C;
   localparam int OFS_WIDTH = OFS_MINY + C;
   localparam int OFS_COUNT = OFS_WIDTH + C + 1;

   tbr_pkg::dp_cmd_type            cmd;
   tbr_pkg::dp_status_type         status;
   logic [tbr_pkg::COLOR_BITS-1:0] color;
   logic [C-1:0]                   frag_x;
   logic [C-1:0]                   frag_y;
   logic [tbr_pkg::DEPTH_BITS-1:0] frag_z;
   logic [tbr_pkg::COLOR_BITS-1:0] frag_color;

   tbr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .color       (color)
   );

   tbr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_mode  (req_tuser),
      .status    (status),
      .req_ready (req_tready),
      .cmd       (cmd)
   );

   tbr_dp #(
      .COORD_BITS (COORD_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .vert0_x    (req_tdata[C-1:0]),
      .vert0_y    (req_tdata[2*C-1:C]),
      .vert1_x    (req_tdata[3*C-1:2*C]),
      .vert1_y    (req_tdata[4*C-1:3*C]),
      .vert2_x    (req_tdata[5*C-1:4*C]),
      .vert2_y    (req_tdata[6*C-1:5*C]),
      .depth_in   (req_tdata[OFS_MINX-1:OFS_DEPTH]),
      .box_min_x  (req_tdata[OFS_MINY-1:OFS_MINX]),
      .box_min_y  (req_tdata[OFS_WIDTH-1:OFS_MINY]),
      .box_width  (req_tdata[OFS_COUNT-1:OFS_WIDTH]),
      .box_count  (req_tdata[OFS_COUNT+COUNT_BITS-1:OFS_COUNT]),
      .color      (color),
      .rsp_ready  (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .covered    (rsp_tuser),
      .frag_x     (frag_x),
      .frag_y     (frag_y),
      .frag_z     (frag_z),
      .frag_color (frag_color),
      .scan_done  (rsp_tlast)
   );

   // pack the result, zero fill to whole bytes
   assign rsp_tdata = RSP_TDATA_BITS'({frag_color, frag_z, frag_y, frag_x});

endmodule

// ===== hdl/tbr_checker.sv =====
// Port-level checks for the rasterizer core, bound to the top level.
// Depends on tbr_pkg and triangle_bbox_rasterizer_core_defines.svh.
`include "triangle_bbox_rasterizer_core_defines.svh"

module tbr_checker #(
   parameter int COORD_BITS = tbr_pkg::COORD_BITS_DEF,
   parameter int COUNT_BITS = tbr_pkg::COUNT_BITS_DEF,
   localparam int REQ_BITS       = 9 * COORD_BITS + 9 + COUNT_BITS,
   localparam int REQ_TDATA_BITS = ((REQ_BITS + 7) / 8) * 8,
   localparam int RSP_BITS       = 2 * COORD_BITS + tbr_pkg::DEPTH_BITS + tbr_pkg::COLOR_BITS,
   localparam int RSP_TDATA_BITS = ((RSP_BITS + 7) / 8) * 8
) (
   input logic                              clock,
   input logic                              reset,
   input logic [REQ_TDATA_BITS-1:0]         req_tdata,
   input logic                              req_tuser,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [RSP_TDATA_BITS-1:0]         rsp_tdata,
   input logic                              rsp_tuser,
   input logic                              rsp_tlast,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic                              csr_psel,
   input logic                              csr_penable,
   input logic                              csr_pwrite,
   input logic [tbr_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input logic [tbr_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   input logic [tbr_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   input logic                              csr_pready
);

   // one item in flight: no acceptance right after an acceptance
   `TBR_ASSERT_NXT(a_one_in_flight, clock, reset, req_tvalid && req_tready, !req_tready, "item accepted while previous one in flight")

   // reset empties the result register and reopens the input
   `TBR_ASSERT_NXT(a_reset_state, clock, 1'b0, reset, !rsp_tvalid && req_tready, "bad state after reset")

   // a color write reads back on the next cycle
   `TBR_ASSERT_NXT(a_color_readback, clock, reset, csr_psel && csr_penable && csr_pwrite && csr_pready && (csr_paddr[2] == 1'b0), (csr_paddr[2] != 1'b0) || (csr_prdata[7:0] == $past(csr_pwdata[7:0])), "fragment color readback mismatch")

   // a stalled result holds
   `TBR_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "stalled result changed")

endmodule

bind triangle_bbox_rasterizer_core tbr_checker #(
   .COORD_BITS (COORD_BITS),
   .COUNT_BITS (COUNT_BITS)
) u_tbr_checker (.*);
